// ===== hw/rtl/psb_pkg.sv =====
// Shared types and constants of the priority schedule builder.
package psb_pkg;

  // Default store depth
  localparam int unsigned MaxProcsDef = 16;

  // Field widths
  localparam int unsigned NumW   = 5;
  localparam int unsigned BurstW = 16;
  localparam int unsigned PrioW  = 8;
  localparam int unsigned TickW  = 20;
  localparam int unsigned TimeW  = 21;
  localparam int unsigned WaitW  = 24;

  // One stored job
  typedef struct packed {
    logic [NumW-1:0]   number;
    logic [BurstW-1:0] burst;
    logic [PrioW-1:0]  prio;
  } psb_entry_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT_I,
    ST_SORT_LD,
    ST_SORT_CMP,
    ST_SORT_WB,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } psb_state_e;

  // Datapath controls from the sequencer
  typedef struct packed {
    logic mem_we;       // write job store
    logic wr_from_cur;  // write data is the held entry, else the input word
    logic cur_load;     // held entry takes the store read data
    logic emit;         // produce one result from the read data
    logic emit_last;    // that result closes the schedule
  } psb_ctrl_t;

endpackage

// ===== hw/rtl/psb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module psb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/psb_ctrl.sv =====
// Sequencer: load counting, exchange-sort loop indexes and emission count.
module psb_ctrl import psb_pkg::*; #(
  parameter int unsigned MaxProcs = MaxProcsDef,
  localparam int unsigned AddrW = (MaxProcs > 1) ? $clog2(MaxProcs) : 1,
  localparam int unsigned CntW  = $clog2(MaxProcs + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             is_last_i,
  input  logic             swap_i,
  output logic             busy_o,
  output psb_ctrl_t        ctrl_o,
  output logic [AddrW-1:0] waddr_o,
  output logic [AddrW-1:0] raddr_o
);

  psb_state_e    state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] i_q, i_d;
  logic [CntW-1:0] j_q, j_d;
  logic [CntW-1:0] k_q, k_d;
  logic [CntW-1:0] i_inc, j_inc, k_inc;

  assign i_inc = i_q + CntW'(1);
  assign j_inc = j_q + CntW'(1);
  assign k_inc = k_q + CntW'(1);

  // State and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  // Next state and controls
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    ctrl_o  = '0;
    waddr_o = count_q[AddrW-1:0];
    raddr_o = '0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          // store the job unless the set is full
          if (count_q < CntW'(MaxProcs)) begin
            ctrl_o.mem_we = 1'b1;
            count_d       = count_q + CntW'(1);
          end
          if (is_last_i) begin
            i_d     = '0;
            state_d = ST_SORT_I;
          end
        end
      end

      ST_SORT_I: begin
        // outer pass ends when no later entry is left
        if (i_inc >= count_q) begin
          k_d     = '0;
          state_d = ST_EMIT_RD;
        end else begin
          raddr_o = i_q[AddrW-1:0];
          state_d = ST_SORT_LD;
        end
      end

      ST_SORT_LD: begin
        // hold entry i, fetch entry i+1
        ctrl_o.cur_load = 1'b1;
        j_d             = i_inc;
        raddr_o         = i_inc[AddrW-1:0];
        state_d         = ST_SORT_CMP;
      end

      ST_SORT_CMP: begin
        // exchange: held entry goes to slot j, entry j becomes held
        if (swap_i) begin
          ctrl_o.mem_we      = 1'b1;
          ctrl_o.wr_from_cur = 1'b1;
          ctrl_o.cur_load    = 1'b1;
        end
        waddr_o = j_q[AddrW-1:0];
        j_d     = j_inc;
        if (j_inc == count_q) begin
          state_d = ST_SORT_WB;
        end else begin
          raddr_o = j_inc[AddrW-1:0];
        end
      end

      ST_SORT_WB: begin
        // settle slot i
        ctrl_o.mem_we      = 1'b1;
        ctrl_o.wr_from_cur = 1'b1;
        waddr_o            = i_q[AddrW-1:0];
        i_d                = i_inc;
        state_d            = ST_SORT_I;
      end

      ST_EMIT_RD: begin
        raddr_o = k_q[AddrW-1:0];
        state_d = ST_EMIT_OUT;
      end

      ST_EMIT_OUT: begin
        ctrl_o.emit = 1'b1;
        if (k_inc == count_q) begin
          ctrl_o.emit_last = 1'b1;
          count_d          = '0;
          state_d          = ST_IDLE;
        end else begin
          raddr_o = k_inc[AddrW-1:0];
          k_d     = k_inc;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  // Checks
  a_cmp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SORT_CMP) |-> (j_q > i_q && j_q < count_q))
    else $error("sort index j out of range");

  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_OUT) |-> (k_q < count_q))
    else $error("emit index beyond job count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxProcs))
    else $error("job count above store depth");

endmodule

// ===== hw/rtl/priority_schedule_builder_unit.sv =====
// Top level of the priority schedule builder: job store, compare unit and timing datapath.
//
// Jobs are loaded one word per cycle while busy_o is low; each gets its arrival
// number from 1, and words beyond MaxProcs are dropped. The word with is_last_i
// set closes the set: busy_o rises and the block runs an in-place exchange sort
// on priority through one shared comparator and the one-write, one-read job store.
// It then streams one result per cycle in run order on result_strobe_o. Results
// cannot be held off: the receiver must take each word in the cycle its strobe
// is high. total_wait_o is nonzero only on the word with final_result_o set, and
// busy_o is already low in that cycle, so the next set may start loading at once.
module priority_schedule_builder_unit import psb_pkg::*; #(
  parameter int unsigned MaxProcs = MaxProcsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [BurstW-1:0] burst_time_i,
  input  logic [PrioW-1:0]  job_priority_i,
  input  logic              is_last_i,
  output logic              result_strobe_o,
  output logic [NumW-1:0]   job_number_o,
  output logic [TickW-1:0]  start_tick_o,
  output logic [TickW-1:0]  end_tick_o,
  output logic [WaitW-1:0]  total_wait_o,
  output logic              final_result_o
);

  localparam int unsigned AddrW  = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
  localparam int unsigned EntryW = $bits(psb_entry_t);

  psb_ctrl_t        ctrl;
  logic [AddrW-1:0] waddr, raddr;
  logic             swap;
  psb_entry_t       in_entry, wdata, rdata, cur_q;
  logic [EntryW-1:0] rdata_raw;

  logic [TimeW-1:0] time_q, time_d;
  logic [WaitW-1:0] wait_q, wait_d;
  logic [TimeW-1:0] end_time;

  logic             strobe_q;
  logic [NumW-1:0]  number_q;
  logic [TickW-1:0] start_q, end_q;
  logic [WaitW-1:0] total_q;
  logic             final_q;

  // Sequencer
  psb_ctrl #(
    .MaxProcs (MaxProcs)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .is_last_i (is_last_i),
    .swap_i    (swap),
    .busy_o    (busy_o),
    .ctrl_o    (ctrl),
    .waddr_o   (waddr),
    .raddr_o   (raddr)
  );

  // Incoming job word; number is the load slot plus one
  always_comb begin
    in_entry.number = NumW'({1'b0, waddr} + (AddrW + 1)'(1));
    in_entry.burst  = burst_time_i;
    in_entry.prio   = job_priority_i;
  end

  assign wdata = ctrl.wr_from_cur ? cur_q : in_entry;

  // Job store
  psb_ram #(
    .Width (EntryW),
    .Depth (MaxProcs)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ctrl.mem_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  assign rdata = psb_entry_t'(rdata_raw);

  // Shared priority comparator
  assign swap = (cur_q.prio > rdata.prio);

  // Held entry of the current outer pass
  always_ff @(posedge clk_i) begin
    if (ctrl.cur_load) begin
      cur_q <= rdata;
    end
  end

  // Tick and wait accumulation
  assign end_time = time_q + TimeW'(rdata.burst);

  always_comb begin
    time_d = time_q;
    wait_d = wait_q;
    if (ctrl.emit) begin
      time_d = end_time;
      if (rdata.burst != '0) begin
        wait_d = wait_q + WaitW'(time_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
      wait_q <= '0;
    end else if (ctrl.emit_last) begin
      time_q <= '0;
      wait_q <= '0;
    end else begin
      time_q <= time_d;
      wait_q <= wait_d;
    end
  end

  // Result word registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
      final_q  <= 1'b0;
      total_q  <= '0;
    end else begin
      strobe_q <= ctrl.emit;
      final_q  <= ctrl.emit_last;
      total_q  <= ctrl.emit_last ? wait_d : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      number_q <= rdata.number;
      start_q  <= time_q[TickW-1:0];
      end_q    <= end_time[TickW-1:0];
    end
  end

  assign result_strobe_o = strobe_q;
  assign job_number_o    = number_q;
  assign start_tick_o    = start_q;
  assign end_tick_o      = end_q;
  assign total_wait_o    = total_q;
  assign final_result_o  = final_q;

  // Checks
  a_final_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    final_result_o |-> (result_strobe_o && !busy_o))
    else $error("final word seen while still busy");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !final_result_o) |-> busy_o)
    else $error("schedule ended before its final word");

  a_wait_only_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !final_result_o) |-> (total_wait_o == '0))
    else $error("total wait shown on a non-final word");

endmodule
